// ----- hw/rtl/clo_pkg.sv -----
// ============================================================================
// Compacting ordered list package
// Shared command codes, sequencer states and the broadcast control word that
// the top level sends to every cell of the list.
// ============================================================================
package clo_pkg;

	// Commands carried on the command channel.
	typedef enum logic [2:0] {
		CMD_PUSH         = 3'd0,
		CMD_POP          = 3'd1,
		CMD_READ_AT      = 3'd2,
		CMD_WRITE_AT     = 3'd3,
		CMD_REMOVE_AT    = 3'd4,
		CMD_REMOVE_VALUE = 3'd5,
		CMD_FIND         = 3'd6,
		CMD_CLEAR        = 3'd7
	} clo_cmd_t;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_PICK,
		ST_READ,
		ST_APPLY
	} clo_state_t;

	// Control word broadcast to all cells.
	typedef struct packed {
		logic cmp_value; // compare stored handle instead of cell index
		logic load;      // selected cell takes the broadcast handle
		logic shift;     // cells at or above the selected one take the upper neighbor
	} clo_cell_ctrl_t;

endpackage

// ----- hw/rtl/clo_if.sv -----
// ============================================================================
// Compacting ordered list channels
// Valid/ready channels for commands into the list and results out of it.
// ============================================================================
interface clo_cmd_if #(
	parameter int unsigned PW = 6,
	parameter int unsigned HW = 16
);
	import clo_pkg::*;

	logic           valid;
	logic           ready;
	clo_cmd_t       command;
	logic [PW-1:0]  position;
	logic [HW-1:0]  handle;

	modport source (output valid, output command, output position, output handle,
		input ready);
	modport sink (input valid, input command, input position, input handle,
		output ready);
endinterface

interface clo_rsp_if #(
	parameter int unsigned PW = 6,
	parameter int unsigned HW = 16,
	parameter int unsigned CW = 7
);
	logic           valid;
	logic           ready;
	logic [HW-1:0]  item;
	logic           ok;
	logic [PW-1:0]  found_position;
	logic [CW-1:0]  count;

	modport source (output valid, output item, output ok, output found_position,
		output count, input ready);
	modport sink (input valid, input item, input ok, input found_position,
		input count, output ready);
endinterface

// ----- hw/rtl/clo_cell.sv -----
// ============================================================================
// List cell
// Holds one list entry, flags whether it is the target of the current
// command, and takes a new handle or its upper neighbor's entry on request.
// ============================================================================
module clo_cell #(
	parameter int unsigned HW    = 16,
	parameter int unsigned CW    = 7,
	parameter int unsigned INDEX = 0
) (
	input  logic                    clk,
	input  clo_pkg::clo_cell_ctrl_t ctrl,
	input  logic [HW-1:0]           handle,
	input  logic [CW-1:0]           target,
	input  logic [CW-1:0]           limit,
	input  logic                    pick,
	input  logic                    at_or_above,
	input  logic [HW-1:0]           upper,
	output logic [HW-1:0]           entry,
	output logic                    match
);
	import clo_pkg::*;

	localparam logic [CW-1:0] IDX = CW'(INDEX);

	logic [HW-1:0] entry_q;

	assign entry = entry_q;

	// A cell only answers when its index lies below the limit: the live part of the list, or the whole row for a push.
	assign match = (ctrl.cmp_value ? (entry_q == handle) : (IDX == target)) && (IDX < limit);

	always_ff @(posedge clk) begin
		if (ctrl.load && pick) begin
			entry_q <= handle;
		end else if (ctrl.shift && at_or_above) begin
			entry_q <= upper;
		end
	end

endmodule

// ----- hw/rtl/clo_pick.sv -----
// ============================================================================
// First-match picker
// Isolates the lowest set match bit and builds the mask of all cells at or
// above it, which drives compaction.
// ============================================================================
module clo_pick #(
	parameter int unsigned N = 64
) (
	input  logic [N-1:0] match,
	output logic [N-1:0] first,
	output logic [N-1:0] ge,
	output logic         hit
);
	import clo_pkg::*;

	assign first = match & (~match + N'(1));
	// With no match, first is zero and the mask comes out empty.
	assign ge    = ~(first - N'(1));
	assign hit   = |match;

endmodule

// ----- hw/rtl/compacting_ordered_list.sv -----
// ============================================================================
// Compacting ordered list
// An ordered list of item handles kept in a row of cells, with push, pop,
// positional read, write and remove, remove by value, find and clear.
// ============================================================================
//
//   Channel | Direction | Handshake    | Payload
//   --------+-----------+--------------+-----------------------------------------
//   cmd     | in        | valid/ready  | command, position, handle
//   rsp     | out       | valid/ready  | item, ok, found_position, count
//
// Every command passes the sequencer states in order from acceptance until its
// result is loaded into the output register: idle accepts it, match lets every
// cell compare, pick isolates the first matching cell, read gathers its index
// and entry, and apply lets the cells write or shift and forms the result.
// A new command is accepted only after the previous one has left apply.
// Reset clears the length and the sequencer; the cell contents are not reset.
// The next command is accepted while an earlier result still waits in the
// output register; a stalled output only holds the apply step of the following
// command until the register is free.
//
module compacting_ordered_list #(
	parameter int unsigned DEPTH        = 64,
	parameter int unsigned HANDLE_WIDTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	clo_cmd_if.sink  cmd,
	clo_rsp_if.source rsp
);
	import clo_pkg::*;

	localparam int unsigned HW = HANDLE_WIDTH;
	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	// Sequencer.
	clo_state_t state_q, state_d;

	// Command captured at acceptance.
	clo_cmd_t       cmd_q;
	logic [HW-1:0]  handle_q;
	logic [CW-1:0]  target_q;
	logic [CW-1:0]  limit_q;

	// List length.
	logic [CW-1:0]  length_q;
	logic [CW-1:0]  length_d;

	// Search results, one step per state.
	logic [DEPTH-1:0] match_q;
	logic [DEPTH-1:0] first_q;
	logic [DEPTH-1:0] ge_q;
	logic             hit_q;
	logic [PW-1:0]    idx_q;
	logic [HW-1:0]    data_q;

	// Output register.
	logic           rsp_valid_q;
	logic [HW-1:0]  rsp_item_q;
	logic           rsp_ok_q;
	logic [PW-1:0]  rsp_fpos_q;
	logic [CW-1:0]  rsp_count_q;

	// Cell row.
	logic [HW-1:0]    cell_data [DEPTH];
	logic [DEPTH-1:0] cell_match;
	clo_cell_ctrl_t   cell_ctrl;

	// Picker and gather.
	logic [DEPTH-1:0] pick_first;
	logic [DEPTH-1:0] pick_ge;
	logic             pick_hit;
	logic [PW-1:0]    enc_idx;
	logic [HW-1:0]    enc_data;

	// Sequencer outputs and result of the apply step.
	logic           accept;
	logic           go;
	logic           res_ok;
	logic [HW-1:0]  res_item;
	logic [PW-1:0]  res_fpos;

	// ------------------------------------------------------------------------
	// Cell row. Each cell hands its entry down to the cell below it, which
	// takes it when a remove compacts the list.
	// ------------------------------------------------------------------------
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [HW-1:0] upper;

		if (i == DEPTH - 1) begin : g_top
			assign upper = cell_data[i];
		end else begin : g_mid
			assign upper = cell_data[i+1];
		end

		clo_cell #(
			.HW    (HW),
			.CW    (CW),
			.INDEX (i)
		) u_cell (
			.clk         (clk),
			.ctrl        (cell_ctrl),
			.handle      (handle_q),
			.target      (target_q),
			.limit       (limit_q),
			.pick        (first_q[i]),
			.at_or_above (ge_q[i]),
			.upper       (upper),
			.entry       (cell_data[i]),
			.match       (cell_match[i])
		);
	end

	clo_pick #(
		.N (DEPTH)
	) u_pick (
		.match (match_q),
		.first (pick_first),
		.ge    (pick_ge),
		.hit   (pick_hit)
	);

	// Gather the index and the entry of the single selected cell.
	always_comb begin
		enc_idx  = '0;
		enc_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_q[i]) begin
				enc_idx  = enc_idx | PW'(i);
				enc_data = enc_data | cell_data[i];
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer: next state.
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: state_d = ST_PICK;
			ST_PICK:  state_d = ST_READ;
			ST_READ:  state_d = ST_APPLY;
			ST_APPLY: begin
				if (go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------------
	// Sequencer: outputs.
	// ------------------------------------------------------------------------
	always_comb begin
		cmd.ready           = 1'b0;
		go                  = 1'b0;
		cell_ctrl.cmp_value = (cmd_q == CMD_FIND) || (cmd_q == CMD_REMOVE_VALUE);
		cell_ctrl.load      = 1'b0;
		cell_ctrl.shift     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
			end
			ST_APPLY: begin
				// The apply step waits until the output register can take the result.
				go              = !rsp_valid_q || rsp.ready;
				cell_ctrl.load  = go && ((cmd_q == CMD_PUSH) || (cmd_q == CMD_WRITE_AT));
				cell_ctrl.shift = go && hit_q &&
					((cmd_q == CMD_REMOVE_AT) || (cmd_q == CMD_REMOVE_VALUE));
			end
			default: begin
				cmd.ready = 1'b0;
			end
		endcase
	end

	assign accept = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------------
	// Command capture. A push targets the cell at the current length and may
	// use any cell; a pop targets the last live cell; the positional commands
	// target the given position inside the live part of the list.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd.command;
			handle_q <= cmd.handle;
			limit_q  <= length_q;
			case (cmd.command)
				CMD_PUSH: begin
					target_q <= length_q;
					limit_q  <= FULL;
				end
				CMD_POP: begin
					target_q <= length_q - CW'(1);
				end
				default: begin
					target_q <= CW'(cmd.position);
				end
			endcase
		end
	end

	// Search pipeline registers, one step of the sequence each.
	always_ff @(posedge clk) begin
		if (state_q == ST_MATCH) begin
			match_q <= cell_match;
		end
		if (state_q == ST_PICK) begin
			first_q <= pick_first;
			ge_q    <= pick_ge;
			hit_q   <= pick_hit;
		end
		if (state_q == ST_READ) begin
			idx_q  <= enc_idx;
			data_q <= enc_data;
		end
	end

	// ------------------------------------------------------------------------
	// Result of the apply step. Without a hit the gathered index and entry
	// are both zero, so a miss reports item and position as zero.
	// ------------------------------------------------------------------------
	always_comb begin
		res_ok   = hit_q;
		res_item = '0;
		res_fpos = '0;
		length_d = length_q;
		case (cmd_q)
			CMD_PUSH: begin
				if (hit_q) begin
					length_d = length_q + CW'(1);
				end
			end
			CMD_POP: begin
				res_item = data_q;
				if (hit_q) begin
					length_d = length_q - CW'(1);
				end
			end
			CMD_READ_AT: begin
				res_item = data_q;
			end
			CMD_WRITE_AT: begin
				res_item = '0;
			end
			CMD_REMOVE_AT: begin
				res_item = data_q;
				if (hit_q) begin
					length_d = length_q - CW'(1);
				end
			end
			CMD_REMOVE_VALUE: begin
				res_item = data_q;
				res_fpos = idx_q;
				if (hit_q) begin
					length_d = length_q - CW'(1);
				end
			end
			CMD_FIND: begin
				res_fpos = idx_q;
			end
			CMD_CLEAR: begin
				res_ok   = 1'b1;
				length_d = '0;
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (go) begin
				length_q    <= length_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rsp_item_q  <= res_item;
			rsp_ok_q    <= res_ok;
			rsp_fpos_q  <= res_fpos;
			rsp_count_q <= length_d;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.item           = rsp_item_q;
	assign rsp.ok             = rsp_ok_q;
	assign rsp.found_position = rsp_fpos_q;
	assign rsp.count          = rsp_count_q;

	// ------------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------------

	// The list never grows past its capacity.
	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= FULL)
		else $error("list length exceeds capacity");

	// At most one cell is selected, and a hit always selects exactly one.
	a_single_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> ($onehot0(first_q) && (hit_q == (first_q != '0))))
		else $error("picker selected other than one cell");

	// A waiting result reports the length the list holds now.
	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_count_q == length_q))
		else $error("reported count differs from list length");

	// A clear empties the list.
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(go && (cmd_q == CMD_CLEAR)) |=> (length_q == '0))
		else $error("clear left entries in the list");

endmodule

// ----- tb/sv/compacting_ordered_list_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Compacting ordered list testbench
// Sends list commands through the command channel and checks every result
// against a shadow copy of the list that the bench keeps. Both channels stall
// at random. The run covers a full list, an empty list and every kind of miss.
// ============================================================================
module compacting_ordered_list_tb;
	import clo_pkg::*;

	localparam int unsigned DEPTH = 64;
	localparam int unsigned HW    = 16;
	localparam int unsigned PW    = 6;
	localparam int unsigned CW    = 7;

	// One list command as the driver sends it.
	typedef struct {
		clo_cmd_t        op;
		logic [PW-1:0]   pos;
		logic [HW-1:0]   h;
	} list_cmd_t;

	// One result as the block should return it.
	typedef struct {
		logic [HW-1:0]   item;
		logic            ok;
		logic [PW-1:0]   fpos;
		logic [CW-1:0]   count;
	} list_result_t;

	// Relative weights of the eight commands, in command code order.
	typedef int unsigned cmd_mix_t [8];

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	clo_cmd_if #(.PW(PW), .HW(HW)) cmd_ch ();
	clo_rsp_if #(.PW(PW), .HW(HW), .CW(CW)) rsp_ch ();

	compacting_ordered_list #(
		.DEPTH        (DEPTH),
		.HANDLE_WIDTH (HW)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always #6 clk = ~clk;

	// Commands waiting to be driven, and results still owed by the block.
	list_cmd_t    pending_cmds[$];
	list_result_t expected_results[$];

	// Shadow copy of the list contents and its length.
	logic [HW-1:0] shadow_entries [DEPTH];
	int            list_len;

	// Random stalls on both channels; cleared for a stretch without any.
	bit            idle_on = 1'b1;

	int            mismatches = 0;
	int            cmd_seen [8];
	int            full_pushes = 0;
	int            empty_pops = 0;
	int            pos_misses = 0;
	int            search_hits = 0;
	int            search_misses = 0;
	int            peak_len = 0;

	logic [HW-1:0] handle_pool [6];
	list_cmd_t     next_cmd;
	list_result_t  want;

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Takes the entry at position p out of the shadow list and closes the gap.
	function automatic logic [HW-1:0] take_entry(input int p);
		logic [HW-1:0] v;
		v = shadow_entries[p];
		for (int i = p; i + 1 < list_len; i++)
			shadow_entries[i] = shadow_entries[i + 1];
		list_len--;
		return v;
	endfunction

	// Applies one accepted command to the shadow list and returns the result
	// that the block owes for it.
	function automatic list_result_t predict_list_op(input clo_cmd_t op,
		input logic [PW-1:0] pos, input logic [HW-1:0] h);
		list_result_t r;
		int idx;
		r.item  = '0;
		r.ok    = 1'b0;
		r.fpos  = '0;
		idx     = -1;
		cmd_seen[op]++;
		case (op)
			CMD_PUSH: begin
				if (list_len < DEPTH) begin
					shadow_entries[list_len] = h;
					list_len++;
					r.ok = 1'b1;
				end else begin
					full_pushes++;
				end
			end
			CMD_POP: begin
				if (list_len > 0) begin
					list_len--;
					r.item = shadow_entries[list_len];
					r.ok   = 1'b1;
				end else begin
					empty_pops++;
				end
			end
			CMD_READ_AT, CMD_WRITE_AT, CMD_REMOVE_AT: begin
				if (int'(pos) < list_len) begin
					r.ok = 1'b1;
					if (op == CMD_READ_AT)
						r.item = shadow_entries[pos];
					else if (op == CMD_WRITE_AT)
						shadow_entries[pos] = h;
					else
						r.item = take_entry(int'(pos));
				end else begin
					pos_misses++;
				end
			end
			CMD_REMOVE_VALUE, CMD_FIND: begin
				// Only the first matching position counts.
				for (int i = 0; i < list_len; i++)
					if (idx < 0 && shadow_entries[i] == h)
						idx = i;
				if (idx >= 0) begin
					search_hits++;
					r.ok   = 1'b1;
					r.fpos = PW'(idx);
					if (op == CMD_REMOVE_VALUE)
						r.item = take_entry(idx);
				end else begin
					search_misses++;
				end
			end
			default: begin
				list_len = 0;
				r.ok     = 1'b1;
			end
		endcase
		if (list_len > peak_len)
			peak_len = list_len;
		r.count = CW'(list_len);
		return r;
	endfunction

	// Driver: an accepted item goes to the predictor; a new item is offered
	// whenever the channel is free, unless this cycle idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid    <= 1'b0;
			cmd_ch.command  <= CMD_PUSH;
			cmd_ch.position <= '0;
			cmd_ch.handle   <= '0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready)
				expected_results.push_back(predict_list_op(cmd_ch.command,
					cmd_ch.position, cmd_ch.handle));
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (pending_cmds.size() > 0 && !(idle_on && $urandom_range(99) < 14)) begin
					next_cmd = pending_cmds.pop_front();
					cmd_ch.valid    <= 1'b1;
					cmd_ch.command  <= next_cmd.op;
					cmd_ch.position <= next_cmd.pos;
					cmd_ch.handle   <= next_cmd.h;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every accepted result is checked against the oldest one owed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					flag_mismatch("result arrived with none outstanding");
				end else begin
					want = expected_results.pop_front();
					if (rsp_ch.item !== want.item)
						flag_mismatch($sformatf("item %h, expected %h",
							rsp_ch.item, want.item));
					if (rsp_ch.ok !== want.ok)
						flag_mismatch($sformatf("ok %b, expected %b",
							rsp_ch.ok, want.ok));
					if (rsp_ch.found_position !== want.fpos)
						flag_mismatch($sformatf("found_position %0d, expected %0d",
							rsp_ch.found_position, want.fpos));
					if (rsp_ch.count !== want.count)
						flag_mismatch($sformatf("count %0d, expected %0d",
							rsp_ch.count, want.count));
				end
			end
			rsp_ch.ready <= !(idle_on && $urandom_range(99) < 14);
		end
	end

	// Keeps only a couple of items ahead of the driver, so that positions
	// drawn from the shadow length stay close to the real list.
	task automatic queue_cmd(input clo_cmd_t op, input logic [PW-1:0] pos,
		input logic [HW-1:0] h);
		list_cmd_t c;
		c.op  = op;
		c.pos = pos;
		c.h   = h;
		while (pending_cmds.size() >= 2)
			@(negedge clk);
		pending_cmds.push_back(c);
	endtask

	// Holds the sender back until every item has been answered.
	task automatic wait_list_quiet();
		while (pending_cmds.size() > 0 || cmd_ch.valid || expected_results.size() > 0)
			@(negedge clk);
	endtask

	// Draws n random commands from the given mix. Handles come mostly from a
	// small pool so that duplicates sit in the list and searches hit.
	task automatic run_mix(input cmd_mix_t mix, input int n);
		int unsigned total;
		int unsigned roll;
		int          k;
		clo_cmd_t    op;
		logic [PW-1:0] pos;
		logic [HW-1:0] h;
		total = 0;
		foreach (mix[j])
			total += mix[j];
		repeat (n) begin
			roll = $urandom_range(total - 1);
			k    = 0;
			while (roll >= mix[k]) begin
				roll -= mix[k];
				k++;
			end
			op = clo_cmd_t'(k);
			if (list_len > 0 && $urandom_range(99) < 80)
				pos = PW'($urandom_range(list_len - 1));
			else
				pos = PW'($urandom_range(DEPTH - 1));
			if ($urandom_range(99) < 70)
				h = handle_pool[$urandom_range(5)];
			else
				h = HW'($urandom);
			queue_cmd(op, pos, h);
		end
	endtask

	initial begin
		// Known values on every block input before the first edge.
		cmd_ch.valid    = 1'b0;
		cmd_ch.command  = CMD_PUSH;
		cmd_ch.position = '0;
		cmd_ch.handle   = '0;
		rsp_ch.ready    = 1'b0;
		list_len = 0;
		foreach (shadow_entries[i])
			shadow_entries[i] = '0;
		foreach (cmd_seen[i])
			cmd_seen[i] = 0;
		handle_pool[0] = 16'h0000;
		handle_pool[1] = 16'hFFFF;
		for (int i = 2; i < 6; i++)
			handle_pool[i] = HW'($urandom);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. The list goes [0, FFFF, 1234, 0], then the second
		// entry is overwritten, and the list is taken apart again, touching
		// null handles, duplicate values, every miss but a push on a full list, and an empty list.
		queue_cmd(CMD_PUSH, 6'd0, 16'h0000);
		queue_cmd(CMD_PUSH, 6'd63, 16'hFFFF);
		queue_cmd(CMD_PUSH, 6'd0, 16'h1234);
		queue_cmd(CMD_PUSH, 6'd0, 16'h0000);
		queue_cmd(CMD_READ_AT, 6'd0, 16'h0000);
		queue_cmd(CMD_READ_AT, 6'd3, 16'h0000);
		queue_cmd(CMD_READ_AT, 6'd4, 16'h0000);
		queue_cmd(CMD_READ_AT, 6'd63, 16'hFFFF);
		queue_cmd(CMD_WRITE_AT, 6'd1, 16'hA5A5);
		queue_cmd(CMD_WRITE_AT, 6'd4, 16'h5A5A);
		queue_cmd(CMD_FIND, 6'd0, 16'h0000);
		queue_cmd(CMD_FIND, 6'd0, 16'hA5A5);
		queue_cmd(CMD_FIND, 6'd0, 16'h5555);
		queue_cmd(CMD_REMOVE_VALUE, 6'd0, 16'h0000);
		queue_cmd(CMD_REMOVE_VALUE, 6'd0, 16'h7777);
		queue_cmd(CMD_REMOVE_AT, 6'd0, 16'h0000);
		queue_cmd(CMD_REMOVE_AT, 6'd5, 16'h0000);
		queue_cmd(CMD_POP, 6'd0, 16'h0000);
		queue_cmd(CMD_POP, 6'd0, 16'h0000);
		queue_cmd(CMD_POP, 6'd0, 16'h0000);
		queue_cmd(CMD_READ_AT, 6'd0, 16'h0000);
		queue_cmd(CMD_CLEAR, 6'd0, 16'h0000);
		queue_cmd(CMD_PUSH, 6'd0, 16'h8001);
		queue_cmd(CMD_CLEAR, 6'd63, 16'hFFFF);
		wait_list_quiet();

		// Random part, in phases that move the list between empty and full.
		run_mix('{18, 12, 14, 12, 12, 12, 14, 2}, 100);
		wait_list_quiet();
		run_mix('{65, 5, 8, 7, 5, 4, 6, 0}, 140);
		wait_list_quiet();
		// Churn near a full list with no stalls on either side.
		idle_on = 1'b0;
		run_mix('{35, 10, 15, 12, 10, 8, 10, 0}, 80);
		wait_list_quiet();
		idle_on = 1'b1;
		run_mix('{8, 30, 10, 8, 25, 12, 7, 0}, 100);
		run_mix('{25, 12, 12, 10, 12, 12, 12, 5}, 80);
		wait_list_quiet();

		// Let any trailing activity in the block settle before closing out.
		repeat (20) @(posedge clk);

		$display("Commands push %0d pop %0d read %0d write %0d remove_at %0d remove_value %0d find %0d clear %0d",
			cmd_seen[CMD_PUSH], cmd_seen[CMD_POP], cmd_seen[CMD_READ_AT],
			cmd_seen[CMD_WRITE_AT], cmd_seen[CMD_REMOVE_AT], cmd_seen[CMD_REMOVE_VALUE],
			cmd_seen[CMD_FIND], cmd_seen[CMD_CLEAR]);
		$display("Pushes on full %0d, pops on empty %0d, position misses %0d, searches %0d hit / %0d missed, peak length %0d, mismatches %0d",
			full_pushes, empty_pops, pos_misses, search_hits, search_misses,
			peak_len, mismatches);
		if (mismatches == 0)
			$display("** compacting_ordered_list: PASSED **");
		else
			$display("** compacting_ordered_list: FAILED **");
		$finish;
	end

	// Watchdog, far beyond the slowest run that could still be correct.
	initial begin
		#5_000_000;
		$display("Timeout with %0d results outstanding", expected_results.size());
		$display("** compacting_ordered_list: FAILED **");
		$finish;
	end

endmodule
